// ===== sv/bmsa_pkg.sv =====
// ---------------------------------------------------------------------------
// bmsa_pkg
// shared widths, codes and types for the banded matrix scatter-accumulate
// ---------------------------------------------------------------------------
package bmsa_pkg;

    // matrix size; the store is MAX_DOF rows by MAX_DOF columns (power of two)
    localparam int MAX_DOF     = 64;
    localparam int IDX_W       = $clog2(MAX_DOF);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = MAX_DOF * MAX_DOF;

    // field widths
    localparam int VAL_W  = 32;
    localparam int ROW_W  = 6;
    localparam int BW_W   = 6;
    localparam int DOF_W  = 7;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 2;
    localparam int SROW_W = 8;

    // apb port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_SKIP  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_SYM  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BAND = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LBW  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_UBW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DOF  = 3'd4;

    localparam logic [DOF_W-1:0] DOF_RESET = 7'd64;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              sym;
        logic              band;
        logic [BW_W-1:0]   lbw;
        logic [BW_W-1:0]   ubw;
        logic [DOF_W-1:0]  dof;
    } t_cfg;

endpackage

// ===== sv/bmsa_in_if.sv =====
// ---------------------------------------------------------------------------
// bmsa_in_if
// input word channel: command, indices, value and local triangle flag
// ---------------------------------------------------------------------------
interface bmsa_in_if import bmsa_pkg::*;;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [ROW_W-1:0]        global_row;
    logic [ROW_W-1:0]        global_col;
    logic signed [VAL_W-1:0] entry_value;
    logic                    in_local_lower;

    modport source (
        output valid, cmd, global_row, global_col, entry_value, in_local_lower,
        input  ready
    );

    modport sink (
        input  valid, cmd, global_row, global_col, entry_value, in_local_lower,
        output ready
    );

endinterface

// ===== sv/bmsa_out_if.sv =====
// ---------------------------------------------------------------------------
// bmsa_out_if
// result word channel: stored value and status
// ---------------------------------------------------------------------------
interface bmsa_out_if import bmsa_pkg::*;;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] stored_value;
    logic [ST_W-1:0]         status;

    modport source (
        output valid, stored_value, status,
        input  ready
    );

    modport sink (
        input  valid, stored_value, status,
        output ready
    );

endinterface

// ===== sv/band_matrix_scatter_accumulate.sv =====
// ---------------------------------------------------------------------------
// band_matrix_scatter_accumulate
// scatter-adds q16.16 element entries into a banded global matrix store
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      cmd, global_row, global_col,
//                                    entry_value, in_local_lower
//  o_out     out  valid / ready      stored_value, status
//  apb       in   psel / penable     paddr, pwdata, prdata (pready tied high)
//
//  an accumulate or read reaches o_out through the issue stage, the execute
//  stage and the output register: address map into the issue stage at the
//  accept edge, ram read into the execute stage, then add, saturate and
//  write back into the output register. back-to-back hits on one entry are
//  forwarded from the last write, so one word is taken per cycle as long as
//  o_out drains. a clear word sweeps all 4096 ram entries one entry a cycle,
//  with input held off; reset starts the same sweep. apb writes go on.
//  a stalled o_out holds the pipe; once the output, execute and issue
//  stages all hold a word, i_in.ready drops.
//
module band_matrix_scatter_accumulate import bmsa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bmsa_in_if.sink               i_in,
    bmsa_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // settings
    t_cfg cfg;

    bmsa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // address map on the incoming word
    logic              map_ok;
    logic [ADDR_W-1:0] map_addr;

    bmsa_map u_map (
        .i_cfg  (cfg),
        .i_row  (i_in.global_row),
        .i_col  (i_in.global_col),
        .o_ok   (map_ok),
        .o_addr (map_addr)
    );

    // issue stage (p): mapped word waiting for its ram read
    logic                    r_p_valid;
    logic [CMD_W-1:0]        r_p_cmd;
    logic [ST_W-1:0]         r_p_status;
    logic [ADDR_W-1:0]       r_p_addr;
    logic signed [VAL_W-1:0] r_p_val;

    // execute stage (q): ram data back, add and write
    logic                    r_q_valid;
    logic [CMD_W-1:0]        r_q_cmd;
    logic [ST_W-1:0]         r_q_status;
    logic [ADDR_W-1:0]       r_q_addr;
    logic signed [VAL_W-1:0] r_q_val;
    logic                    r_q_fwd;
    logic signed [VAL_W-1:0] r_q_fwd_data;

    // output register
    logic                    r_o_valid;
    logic signed [VAL_W-1:0] r_o_value;
    logic [ST_W-1:0]         r_o_status;

    // clear sweep
    logic                    r_clr_busy;
    logic [ADDR_W-1:0]       r_clr_cnt;

    logic                    in_ready;
    logic                    in_acc;
    logic                    clr_pend;
    logic                    p_move;
    logic                    q_move;
    logic [ST_W-1:0]         pre_status;

    logic [VAL_W-1:0]        ram_rdata;
    logic signed [VAL_W-1:0] old_val;
    logic signed [VAL_W:0]   sum_ext;
    logic                    sum_ovf;
    logic signed [VAL_W-1:0] sum_sat;
    logic                    q_ok_acc;
    logic                    q_wr_en;
    logic signed [VAL_W-1:0] q_value;
    logic [ST_W-1:0]         q_status;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;

    // handshake and stage movement
    assign clr_pend = (r_p_valid && r_p_cmd == CMD_CLEAR)
                   || (r_q_valid && r_q_cmd == CMD_CLEAR);
    assign q_move   = r_q_valid && (!r_o_valid || o_out.ready);
    assign p_move   = r_p_valid && (!r_q_valid || q_move);
    assign in_ready = !r_clr_busy && !clr_pend && (!r_p_valid || p_move);
    assign in_acc   = i_in.valid && in_ready;

    assign i_in.ready = in_ready;

    // skip check comes before the range check
    always_comb begin
        unique case (i_in.cmd)
            CMD_ACC: begin
                if (cfg.sym && !i_in.in_local_lower) begin
                    pre_status = ST_SKIP;
                end else if (!map_ok) begin
                    pre_status = ST_RANGE;
                end else begin
                    pre_status = ST_OK;
                end
            end
            CMD_READ:  pre_status = map_ok ? ST_OK : ST_RANGE;
            CMD_CLEAR: pre_status = ST_OK;
            CMD_NONE:  pre_status = ST_OK;
            default:   pre_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (in_acc) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_cmd    <= i_in.cmd;
            r_p_status <= pre_status;
            r_p_addr   <= map_addr;
            r_p_val    <= i_in.entry_value;
        end
    end

    // old value, with the write made at the same edge as this read forwarded
    assign old_val  = r_q_fwd ? r_q_fwd_data : $signed(ram_rdata);
    assign sum_ext  = {old_val[VAL_W-1], old_val} + {r_q_val[VAL_W-1], r_q_val};
    assign sum_ovf  = sum_ext[VAL_W] != sum_ext[VAL_W-1];
    assign sum_sat  = !sum_ovf ? sum_ext[VAL_W-1:0]
                    : (sum_ext[VAL_W] ? VAL_MIN : VAL_MAX);
    assign q_ok_acc = r_q_cmd == CMD_ACC && r_q_status == ST_OK;
    assign q_wr_en  = q_move && q_ok_acc;

    always_comb begin
        q_value  = '0;
        q_status = r_q_status;
        if (r_q_status == ST_OK) begin
            unique case (r_q_cmd)
                CMD_ACC: begin
                    q_value  = sum_sat;
                    q_status = sum_ovf ? ST_SAT : ST_OK;
                end
                CMD_READ:  q_value = old_val;
                CMD_CLEAR: q_value = '0;
                CMD_NONE:  q_value = '0;
                default:   q_value = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_q_fwd   <= 1'b0;
        end else if (p_move) begin
            r_q_valid <= 1'b1;
            r_q_fwd   <= q_wr_en && (r_q_addr == r_p_addr);
        end else if (q_move) begin
            r_q_valid <= 1'b0;
            r_q_fwd   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_q_cmd      <= r_p_cmd;
            r_q_status   <= r_p_status;
            r_q_addr     <= r_p_addr;
            r_q_val      <= r_p_val;
            r_q_fwd_data <= sum_sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (q_move) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_move) begin
            r_o_value  <= q_value;
            r_o_status <= q_status;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.stored_value = r_o_value;
    assign o_out.status       = r_o_status;

    // clear sweep: after reset and when a clear word leaves the execute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            if (r_clr_cnt == '1) begin
                r_clr_busy <= 1'b0;
            end
        end else if (q_move && r_q_cmd == CMD_CLEAR) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end
    end

    // ram write port: sweep or write-back
    assign ram_we    = r_clr_busy || q_wr_en;
    assign ram_waddr = r_clr_busy ? r_clr_cnt : r_q_addr;
    assign ram_wdata = r_clr_busy ? '0 : sum_sat;

    bmsa_ram #(
        .DATA_W (VAL_W),
        .DEPTH  (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (p_move),
        .i_raddr (r_p_addr),
        .o_rdata (ram_rdata)
    );

    // write-back never collides with the clear sweep
    a_no_wb_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr_busy && q_wr_en))
        else $error("write-back during clear sweep");

    // a saturated result always holds a clamp value
    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_SAT) |->
            (r_o_value == VAL_MAX || r_o_value == VAL_MIN))
        else $error("saturated result not clamped");

    // the sweep ends only after the last entry
    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(r_clr_cnt) == '1)
        else $error("clear sweep ended early");

    // forwarding only applies to a word in the execute stage
    a_fwd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_fwd |-> r_q_valid)
        else $error("forward flag without execute word");

endmodule

// ===== sv/bmsa_cfg.sv =====
// ---------------------------------------------------------------------------
// bmsa_cfg
// apb register file for the layout and range settings
// ---------------------------------------------------------------------------
module bmsa_cfg import bmsa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sym  <= 1'b0;
            r_cfg.band <= 1'b0;
            r_cfg.lbw  <= '0;
            r_cfg.ubw  <= '0;
            r_cfg.dof  <= DOF_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SYM:  r_cfg.sym  <= pwdata[0];
                REG_BAND: r_cfg.band <= pwdata[0];
                REG_LBW:  r_cfg.lbw  <= pwdata[BW_W-1:0];
                REG_UBW:  r_cfg.ubw  <= pwdata[BW_W-1:0];
                REG_DOF:  r_cfg.dof  <= pwdata[DOF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SYM:  prdata = APB_DATA_W'(r_cfg.sym);
            REG_BAND: prdata = APB_DATA_W'(r_cfg.band);
            REG_LBW:  prdata = APB_DATA_W'(r_cfg.lbw);
            REG_UBW:  prdata = APB_DATA_W'(r_cfg.ubw);
            REG_DOF:  prdata = APB_DATA_W'(r_cfg.dof);
            default:  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/bmsa_map.sv =====
// ---------------------------------------------------------------------------
// bmsa_map
// maps a global (row, col) pair to a store address under the active layout
// ---------------------------------------------------------------------------
module bmsa_map import bmsa_pkg::*; (
    input  t_cfg              i_cfg,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [ROW_W-1:0]  i_col,
    output logic              o_ok,
    output logic [ADDR_W-1:0] o_addr
);

    logic [DOF_W-1:0]  dof_eff;
    logic              in_rng;
    logic              r_gt;
    logic [ROW_W-1:0]  diff;
    logic [ROW_W-1:0]  mx;
    logic [ROW_W-1:0]  mn;
    logic [SROW_W-1:0] rlu;
    logic              under;
    logic [SROW_W-1:0] srow;
    logic [ROW_W-1:0]  scol;
    logic [SROW_W-1:0] rows;

    // effective dof count is capped by the store size
    assign dof_eff = (32'(i_cfg.dof) > MAX_DOF) ? DOF_W'(MAX_DOF) : i_cfg.dof;
    assign in_rng  = (DOF_W'(i_row) < dof_eff) && (DOF_W'(i_col) < dof_eff);

    assign r_gt = i_row > i_col;
    assign diff = r_gt ? (i_row - i_col) : (i_col - i_row);
    assign mx   = r_gt ? i_row : i_col;
    assign mn   = r_gt ? i_col : i_row;

    // unsymmetric band row is r + L + U - c, below zero means out of band
    assign rlu   = SROW_W'(i_row) + SROW_W'(i_cfg.lbw) + SROW_W'(i_cfg.ubw);
    assign under = rlu < SROW_W'(i_col);

    always_comb begin
        unique case ({i_cfg.sym, i_cfg.band})
            2'b11: begin
                srow = SROW_W'(diff);
                scol = mn;
                rows = SROW_W'(i_cfg.lbw) + SROW_W'(1);
            end
            2'b10: begin
                srow = SROW_W'(mx);
                scol = mn;
                rows = SROW_W'(dof_eff);
            end
            2'b01: begin
                srow = rlu - SROW_W'(i_col);
                scol = i_col;
                rows = SROW_W'({i_cfg.lbw, 1'b0}) + SROW_W'(i_cfg.ubw) + SROW_W'(1);
            end
            default: begin
                srow = SROW_W'(i_row);
                scol = i_col;
                rows = SROW_W'(dof_eff);
            end
        endcase
    end

    assign o_ok = in_rng && !(i_cfg.band && !i_cfg.sym && under)
               && (srow < rows) && (32'(srow) < MAX_DOF) && (32'(scol) < MAX_DOF);

    assign o_addr = ADDR_W'(32'(srow) * MAX_DOF + 32'(scol));

endmodule

// ===== sv/bmsa_ram.sv =====
// ---------------------------------------------------------------------------
// bmsa_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module bmsa_ram import bmsa_pkg::*; #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read during write returns the old word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
